FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hw/rtl/ltc_pkg.sv
`default_nettype none
package ltc_pkg;

  localparam int TOTAL_WIDTH       = 32;
  localparam int TOKEN_COUNT_WIDTH = 16;
  localparam int ADD_W = ((TOTAL_WIDTH > TOKEN_COUNT_WIDTH) ?
                          TOTAL_WIDTH : TOKEN_COUNT_WIDTH) + 1;
  localparam int SUM_W = TOTAL_WIDTH + 3;

  // Keyword table, one row per keyword, zero padded to eight slots
  localparam int NUM_KW   = 5;
  localparam int KW_SLOTS = 8;
  localparam logic [7:0] KW_TEXT [NUM_KW][KW_SLOTS] = '{
    '{8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // int
    '{8'h66, 8'h6c, 8'h6f, 8'h61, 8'h74, 8'h00, 8'h00, 8'h00},  // float
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // if
    '{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},  // else
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e, 8'h00, 8'h00}   // return
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd5, 3'd2, 3'd4, 3'd6};
  localparam logic [2:0] POS_MAX = 3'd7;

  // Total slots
  localparam int NUM_TOTALS = 5;
  localparam int IDX_KEYWORD    = 0;
  localparam int IDX_CONSTANT   = 1;
  localparam int IDX_IDENTIFIER = 2;
  localparam int IDX_OPERATOR   = 3;
  localparam int IDX_PUNCT      = 4;

  // Event queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [2:0] {
    CLS_KEYWORD    = 3'd0,
    CLS_CONSTANT   = 3'd1,
    CLS_IDENTIFIER = 3'd2,
    CLS_OTHER      = 3'd3,
    CLS_NONE       = 3'd4
  } token_class_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    token_class_t                 token_class;
    logic [TOKEN_COUNT_WIDTH-1:0] ops_in_token;
    logic [TOKEN_COUNT_WIDTH-1:0] punct_in_token;
    logic [TOTAL_WIDTH-1:0]       keyword_total;
    logic [TOTAL_WIDTH-1:0]       constant_total;
    logic [TOTAL_WIDTH-1:0]       identifier_total;
    logic [TOTAL_WIDTH-1:0]       operator_total;
    logic [TOTAL_WIDTH-1:0]       punct_total;
    logic [TOTAL_WIDTH-1:0]       token_total;
    logic                         is_final;
  } out_item_t;

  // Closed-token event passed from front to back
  typedef struct packed {
    token_class_t                 token_class;
    logic [TOKEN_COUNT_WIDTH-1:0] ops;
    logic [TOKEN_COUNT_WIDTH-1:0] punct;
    logic                         is_final;
  } tok_evt_t;

  // Saturating add of a per-token count into a running total
  function automatic logic [TOTAL_WIDTH-1:0] sat_add_total(
    input logic [TOTAL_WIDTH-1:0]       a,
    input logic [TOKEN_COUNT_WIDTH-1:0] b
  );
    logic [ADD_W-1:0] s;
    s = ADD_W'(a) + ADD_W'(b);
    return (s[ADD_W-1:TOTAL_WIDTH] != '0) ? '1 : s[TOTAL_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ltc_front.sv
`default_nettype none
`include "assert_macros.svh"
module ltc_front import ltc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     take,
  input  wire in_item_t item,
  output logic          push,
  output tok_evt_t      evt
);

  logic                         in_token;
  logic [NUM_KW-1:0]            keyword_alive;
  logic [2:0]                   char_position;
  logic                         number_ok;
  logic                         seen_point;
  logic                         ident_ok;
  logic [TOKEN_COUNT_WIDTH-1:0] token_ops;
  logic [TOKEN_COUNT_WIDTH-1:0] token_punct;

  logic                         in_token_next;
  logic [NUM_KW-1:0]            keyword_alive_next;
  logic [2:0]                   char_position_next;
  logic                         number_ok_next;
  logic                         seen_point_next;
  logic                         ident_ok_next;
  logic [TOKEN_COUNT_WIDTH-1:0] token_ops_next;
  logic [TOKEN_COUNT_WIDTH-1:0] token_punct_next;

  logic [7:0] c;
  logic       is_space, is_digit, is_letter, is_op, is_punct;
  logic       do_close, kw_hit;
  token_class_t cls;

  // Character classes
  always_comb begin
    c         = item.char_code;
    is_space  = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    is_digit  = (c >= 8'h30) && (c <= 8'h39);
    is_letter = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    is_op     = (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2a) || (c == 8'h2f) ||
                (c == 8'h3d) || (c == 8'h3c) || (c == 8'h3e) || (c == 8'h21);
    is_punct  = (c == 8'h2c) || (c == 8'h3b) || (c == 8'h28) || (c == 8'h29) ||
                (c == 8'h7b) || (c == 8'h7d);
  end

  // Token state after absorbing this byte (unchanged on whitespace)
  always_comb begin
    in_token_next      = in_token;
    keyword_alive_next = keyword_alive;
    char_position_next = char_position;
    number_ok_next     = number_ok;
    seen_point_next    = seen_point;
    ident_ok_next      = ident_ok;
    token_ops_next     = token_ops;
    token_punct_next   = token_punct;
    if (!is_space) begin
      for (int k = 0; k < NUM_KW; k++) begin
        if ((char_position >= KW_LEN[k]) || (KW_TEXT[k][char_position] != c)) begin
          keyword_alive_next[k] = 1'b0;
        end
      end
      if (c == 8'h2e) begin
        if (seen_point) begin
          number_ok_next = 1'b0;
        end
        seen_point_next = 1'b1;
      end else if (!is_digit) begin
        number_ok_next = 1'b0;
      end
      if (!in_token) begin
        if (!is_letter && (c != 8'h5f)) begin
          ident_ok_next = 1'b0;
        end
      end else if (!is_letter && !is_digit && (c != 8'h5f)) begin
        ident_ok_next = 1'b0;
      end
      if (is_op) begin
        if (token_ops != '1) begin
          token_ops_next = token_ops + TOKEN_COUNT_WIDTH'(1);
        end
      end else if (is_punct) begin
        if (token_punct != '1) begin
          token_punct_next = token_punct + TOKEN_COUNT_WIDTH'(1);
        end
      end
      if (char_position != POS_MAX) begin
        char_position_next = char_position + 3'd1;
      end
      in_token_next = 1'b1;
    end
  end

  // Classify the token as it stands after this byte
  always_comb begin
    kw_hit = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (keyword_alive_next[k] && (char_position_next == KW_LEN[k])) begin
        kw_hit = 1'b1;
      end
    end
    if (!in_token_next) begin
      cls = CLS_NONE;
    end else if (kw_hit) begin
      cls = CLS_KEYWORD;
    end else if (number_ok_next) begin
      cls = CLS_CONSTANT;
    end else if (ident_ok_next) begin
      cls = CLS_IDENTIFIER;
    end else begin
      cls = CLS_OTHER;
    end
  end

  // Event out when a token closes or the text ends
  always_comb begin
    do_close          = item.is_last || (is_space && in_token);
    push              = take && do_close;
    evt.token_class   = cls;
    evt.ops           = (cls == CLS_OTHER) ? token_ops_next : '0;
    evt.punct         = (cls == CLS_OTHER) ? token_punct_next : '0;
    evt.is_final      = item.is_last;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && do_close)) begin
      in_token      <= 1'b0;
      keyword_alive <= '1;
      char_position <= '0;
      number_ok     <= 1'b1;
      seen_point    <= 1'b0;
      ident_ok      <= 1'b1;
      token_ops     <= '0;
      token_punct   <= '0;
    end else if (take) begin
      in_token      <= in_token_next;
      keyword_alive <= keyword_alive_next;
      char_position <= char_position_next;
      number_ok     <= number_ok_next;
      seen_point    <= seen_point_next;
      ident_ok      <= ident_ok_next;
      token_ops     <= token_ops_next;
      token_punct   <= token_punct_next;
    end
  end

  `ASSERT_IMPLIES(a_none_is_final, clk, rst, push && (evt.token_class == CLS_NONE), evt.is_final)
  `ASSERT_IMPLIES(a_counts_other_only, clk, rst, push && (evt.token_class != CLS_OTHER),
                  (evt.ops == '0) && (evt.punct == '0))

endmodule
`default_nettype wire

FILE: hw/rtl/ltc_queue.sv
`default_nettype none
`include "assert_macros.svh"
module ltc_queue import ltc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire tok_evt_t push_evt,
  output logic          full,
  input  wire logic     pop,
  output logic          head_valid,
  output tok_evt_t      head_evt
);

  tok_evt_t        slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full       = (count == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_evt   = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_evt;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (Q_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (Q_AW+1)'(1);
      end
    end
  end

  `ASSERT_IMPLIES(a_no_push_full, clk, rst, push, !full)
  `ASSERT_IMPLIES(a_no_pop_empty, clk, rst, pop, head_valid)

endmodule
`default_nettype wire

FILE: hw/rtl/ltc_back.sv
`default_nettype none
`include "assert_macros.svh"
module ltc_back import ltc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     head_valid,
  input  wire tok_evt_t head_evt,
  output logic          pop,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  logic [TOTAL_WIDTH-1:0] totals      [NUM_TOTALS];
  logic [TOTAL_WIDTH-1:0] totals_next [NUM_TOTALS];
  logic [TOTAL_WIDTH-1:0] base        [NUM_TOTALS];
  logic                   clear_pending;
  logic                   a_valid;
  tok_evt_t               a_evt;
  logic                   a_move;
  logic [SUM_W-1:0]       sum_wide;
  logic [TOTAL_WIDTH-1:0] sum_sat;

  assign a_move = a_valid && (!out_valid || !out_stall);
  assign pop    = head_valid && (!a_valid || a_move);

  // Totals restart from zero after a final result
  always_comb begin
    for (int i = 0; i < NUM_TOTALS; i++) begin
      base[i] = clear_pending ? '0 : totals[i];
    end
  end

  // Totals after applying the closed token at the queue head
  always_comb begin
    for (int i = 0; i < NUM_TOTALS; i++) begin
      totals_next[i] = base[i];
    end
    unique case (head_evt.token_class)
      CLS_KEYWORD: begin
        totals_next[IDX_KEYWORD] = sat_add_total(base[IDX_KEYWORD], TOKEN_COUNT_WIDTH'(1));
      end
      CLS_CONSTANT: begin
        totals_next[IDX_CONSTANT] = sat_add_total(base[IDX_CONSTANT], TOKEN_COUNT_WIDTH'(1));
      end
      CLS_IDENTIFIER: begin
        totals_next[IDX_IDENTIFIER] = sat_add_total(base[IDX_IDENTIFIER],
                                                    TOKEN_COUNT_WIDTH'(1));
      end
      CLS_OTHER: begin
        totals_next[IDX_OPERATOR] = sat_add_total(base[IDX_OPERATOR], head_evt.ops);
        totals_next[IDX_PUNCT]    = sat_add_total(base[IDX_PUNCT], head_evt.punct);
      end
      default: begin
      end
    endcase
  end

  // Apply one closed token to the running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TOTALS; i++) begin
        totals[i] <= '0;
      end
      clear_pending <= 1'b0;
    end else if (pop) begin
      for (int i = 0; i < NUM_TOTALS; i++) begin
        totals[i] <= totals_next[i];
      end
      clear_pending <= head_evt.is_final;
    end
  end

  // Stage holding the event whose totals are in place
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pop) begin
      a_valid <= 1'b1;
    end else if (a_move) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_evt <= head_evt;
    end
  end

  // Saturating sum of the five totals
  always_comb begin
    sum_wide = '0;
    for (int i = 0; i < NUM_TOTALS; i++) begin
      sum_wide = sum_wide + SUM_W'(totals[i]);
    end
    sum_sat = (sum_wide[SUM_W-1:TOTAL_WIDTH] != '0) ? '1 : sum_wide[TOTAL_WIDTH-1:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      out_item.token_class      <= a_evt.token_class;
      out_item.ops_in_token     <= a_evt.ops;
      out_item.punct_in_token   <= a_evt.punct;
      out_item.keyword_total    <= totals[IDX_KEYWORD];
      out_item.constant_total   <= totals[IDX_CONSTANT];
      out_item.identifier_total <= totals[IDX_IDENTIFIER];
      out_item.operator_total   <= totals[IDX_OPERATOR];
      out_item.punct_total      <= totals[IDX_PUNCT];
      out_item.token_total      <= sum_sat;
      out_item.is_final         <= a_evt.is_final;
    end
  end

  `ASSERT_IMPLIES(a_sum_covers_kw, clk, rst, out_valid,
                  out_item.token_total >= out_item.keyword_total)
  `ASSERT_NEXT(a_final_clears, clk, rst, pop && head_evt.is_final, clear_pending)

endmodule
`default_nettype wire

FILE: hw/rtl/lexical_token_classifier_core.sv
// Lexical token classifier. Source text enters one byte per cycle unless
// in_stall is raised; whitespace closes a token, which is then classed as
// keyword, constant, identifier or other, and one result item carries the
// class, the operator and punctuation counts of an other-class token, and the
// saturating running totals. A byte marked is_last always gives a final result
// (class "no token" when none was open) and restarts all counting. Throughput
// is one byte per cycle with no gaps while the output is not stalled: the front
// end updates its token state on each accepted byte, a four-entry event queue
// decouples it from the totals unit, and a closing byte's event passes through
// the queue entry, the totals stage and the output register to the result.
// in_stall is raised only while the event queue is full.
`default_nettype none
module lexical_token_classifier_core import ltc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  logic     take;
  logic     push;
  tok_evt_t push_evt;
  logic     full;
  logic     pop;
  logic     head_valid;
  tok_evt_t head_evt;

  assign in_stall = full;
  assign take     = in_valid && !full;

  ltc_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (in_item),
    .push (push),
    .evt  (push_evt)
  );

  ltc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_evt   (push_evt),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_evt   (head_evt)
  );

  ltc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_evt   (head_evt),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import ltc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 520;
  localparam int HOLD_CYCLES  = 60;
  localparam int MAX_REPORTS  = 10;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  lexical_token_classifier_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Character sets
  string kw_words [NUM_KW] = '{"int", "float", "if", "else", "return"};
  string op_chars          = "+-*/=<>!";
  string punct_chars       = ",;(){}";
  logic [7:0] blanks [6]   = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

  // Directed text; cls is checked only on rows marked fixed
  typedef struct {
    logic [7:0]   c;
    bit           last;
    bit           fixed;
    token_class_t cls;
  } dir_row_t;

  dir_row_t dir_tab [25] = '{
    '{CH_SPACE, 0, 0, CLS_NONE},        // blank with nothing open
    '{CH_SPACE, 1, 1, CLS_NONE},        // last byte, no token
    '{"i", 0, 0, CLS_NONE},
    '{"n", 0, 0, CLS_NONE},
    '{"t", 0, 0, CLS_NONE},
    '{CH_SPACE, 0, 1, CLS_KEYWORD},
    '{".", 0, 0, CLS_NONE},             // lone point
    '{CH_TAB, 0, 1, CLS_CONSTANT},
    '{"_", 0, 0, CLS_NONE},
    '{"9", 0, 0, CLS_NONE},
    '{CH_LF, 0, 1, CLS_IDENTIFIER},
    '{8'hFF, 0, 0, CLS_NONE},           // high byte
    '{"+", 0, 0, CLS_NONE},
    '{"(", 0, 0, CLS_NONE},
    '{CH_CR, 0, 1, CLS_OTHER},
    '{8'h00, 0, 0, CLS_NONE},           // NUL byte
    '{CH_VT, 0, 1, CLS_OTHER},
    '{"1", 0, 0, CLS_NONE},
    '{".", 0, 0, CLS_NONE},
    '{".", 0, 0, CLS_NONE},             // second point kills the constant
    '{CH_FF, 0, 1, CLS_OTHER},
    '{"e", 0, 0, CLS_NONE},
    '{"l", 0, 0, CLS_NONE},
    '{"s", 0, 0, CLS_NONE},
    '{"e", 1, 1, CLS_KEYWORD}           // last byte joins the token
  };

  // Lexer state mirrored by the predictor
  bit        lx_open;
  bit [4:0]  lx_kw_live;
  bit [2:0]  lx_pos;
  bit        lx_num_ok;
  bit        lx_point;
  bit        lx_id_ok;
  bit [15:0] lx_ops;
  bit [15:0] lx_punct;
  bit [31:0] lx_totals [NUM_TOTALS];

  out_item_t pending_results [$];

  int  gap_pct   = 0;
  int  stall_pct = 0;
  bit  fix_on    = 0;
  token_class_t fix_cls = CLS_NONE;
  bit  hold_trig = 0;
  bit  hold_seen = 0;
  int  hold_left = 0;

  int  text_items   = 0;
  int  results_seen = 0;
  int  finals_seen  = 0;
  int  stall_cycles = 0;
  int  mismatches   = 0;
  int  cycle_cnt    = 0;

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit [31:0] sat_total(bit [63:0] s);
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void clear_token();
    lx_open    = 0;
    lx_kw_live = '1;
    lx_pos     = 0;
    lx_num_ok  = 1;
    lx_point   = 0;
    lx_id_ok   = 1;
    lx_ops     = 0;
    lx_punct   = 0;
  endfunction

  // Fold one non-blank byte into the open token
  function automatic void absorb_byte(logic [7:0] c);
    for (int k = 0; k < NUM_KW; k++)
      if (lx_pos >= kw_words[k].len() || kw_words[k][lx_pos] != c) lx_kw_live[k] = 0;
    if (c == ".") begin
      if (lx_point) lx_num_ok = 0;
      lx_point = 1;
    end else if (!is_digit(c)) begin
      lx_num_ok = 0;
    end
    if (!lx_open) begin
      if (!is_alpha(c) && c != "_") lx_id_ok = 0;
    end else if (!is_alpha(c) && !is_digit(c) && c != "_") begin
      lx_id_ok = 0;
    end
    if (c == "+" || c == "-" || c == "*" || c == "/" || c == "=" ||
        c == "<" || c == ">" || c == "!") begin
      if (lx_ops != 16'hFFFF) lx_ops++;
    end else if (c == "," || c == ";" || c == "(" || c == ")" ||
                 c == "{" || c == "}") begin
      if (lx_punct != 16'hFFFF) lx_punct++;
    end
    if (lx_pos < 3'd7) lx_pos++;
    lx_open = 1;
  endfunction

  // Class of the open token; bumps the matching totals
  function automatic token_class_t close_token_class();
    bit kw_hit;
    kw_hit = 0;
    for (int k = 0; k < NUM_KW; k++)
      if (lx_kw_live[k] && lx_pos == kw_words[k].len()) kw_hit = 1;
    if (kw_hit) begin
      lx_totals[IDX_KEYWORD] = sat_total(64'(lx_totals[IDX_KEYWORD]) + 64'd1);
      return CLS_KEYWORD;
    end
    if (lx_num_ok) begin
      lx_totals[IDX_CONSTANT] = sat_total(64'(lx_totals[IDX_CONSTANT]) + 64'd1);
      return CLS_CONSTANT;
    end
    if (lx_id_ok) begin
      lx_totals[IDX_IDENTIFIER] = sat_total(64'(lx_totals[IDX_IDENTIFIER]) + 64'd1);
      return CLS_IDENTIFIER;
    end
    lx_totals[IDX_OPERATOR] = sat_total(64'(lx_totals[IDX_OPERATOR]) + 64'(lx_ops));
    lx_totals[IDX_PUNCT]    = sat_total(64'(lx_totals[IDX_PUNCT]) + 64'(lx_punct));
    return CLS_OTHER;
  endfunction

  // Advance the lexer by one byte; returns 1 with the result when one is due
  function automatic bit classify_byte(logic [7:0] c, bit last, output out_item_t r);
    bit           blank;
    token_class_t cls;
    bit [31:0]    sum;
    blank = is_blank(c);
    r     = '0;
    if (!blank) absorb_byte(c);
    if (!last && (!blank || !lx_open)) return 0;
    cls = lx_open ? close_token_class() : CLS_NONE;
    r.token_class      = cls;
    r.ops_in_token     = (cls == CLS_OTHER) ? lx_ops : '0;
    r.punct_in_token   = (cls == CLS_OTHER) ? lx_punct : '0;
    r.keyword_total    = lx_totals[IDX_KEYWORD];
    r.constant_total   = lx_totals[IDX_CONSTANT];
    r.identifier_total = lx_totals[IDX_IDENTIFIER];
    r.operator_total   = lx_totals[IDX_OPERATOR];
    r.punct_total      = lx_totals[IDX_PUNCT];
    sum = 0;
    for (int i = 0; i < NUM_TOTALS; i++) sum = sat_total(64'(sum) + 64'(lx_totals[i]));
    r.token_total = sum;
    r.is_final    = last;
    clear_token();
    if (last)
      for (int i = 0; i < NUM_TOTALS; i++) lx_totals[i] = 0;
    return 1;
  endfunction

  initial begin
    clear_token();
    for (int i = 0; i < NUM_TOTALS; i++) lx_totals[i] = 0;
  end

  // Accepted input items feed the predictor
  always @(posedge clk) begin
    out_item_t r;
    if (!rst && in_valid && !in_stall) begin
      text_items++;
      if (classify_byte(in_item.char_code, in_item.is_last, r)) begin
        if (fix_on) r.token_class = fix_cls;
        pending_results.insert(pending_results.size(), r);
      end
    end
    if (!rst && in_valid && in_stall) stall_cycles++;
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch on %s: expected %0d, got %0d (result %0d)",
                 name, exp_v, act_v, results_seen);
    end
  endtask

  // Compare each accepted result against the oldest expectation
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: class %0d, final %0d",
                   out_item.token_class, out_item.is_final);
      end else begin
        e = pending_results.pop_front();
        check_field("token_class", e.token_class, out_item.token_class);
        check_field("ops_in_token", e.ops_in_token, out_item.ops_in_token);
        check_field("punct_in_token", e.punct_in_token, out_item.punct_in_token);
        check_field("keyword_total", e.keyword_total, out_item.keyword_total);
        check_field("constant_total", e.constant_total, out_item.constant_total);
        check_field("identifier_total", e.identifier_total, out_item.identifier_total);
        check_field("operator_total", e.operator_total, out_item.operator_total);
        check_field("punct_total", e.punct_total, out_item.punct_total);
        check_field("token_total", e.token_total, out_item.token_total);
        check_field("is_final", e.is_final, out_item.is_final);
        if (e.is_final) finals_seen++;
      end
      results_seen++;
    end
  end

  // Receiver: random stalls, or a long hold-off when requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_trig != hold_seen) begin
        hold_seen = hold_trig;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("lexical_token_classifier_core test failed");
      $finish;
    end
  end

  // Offer one byte and hold it until accepted
  task automatic send_byte(logic [7:0] c, bit last, bit fixed = 0,
                           token_class_t cls = CLS_NONE);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    fix_on   = fixed;
    fix_cls  = cls;
    in_valid <= 1'b1;
    in_item  <= '{char_code: c, is_last: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and let every expected result come out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [7:0] ident_char();
    int r;
    r = $urandom_range(62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] sym_char();
    int r;
    r = $urandom_range(13);
    return (r < 8) ? op_chars[r] : punct_chars[r - 8];
  endfunction

  // One random token, usually followed by blank separators, sometimes ending the text
  task automatic send_token();
    logic [7:0] txt [$];
    string      w;
    int         n;
    int         fin_mode;
    case ($urandom_range(9))
      0, 1: begin
        w = kw_words[$urandom_range(NUM_KW - 1)];
        for (int i = 0; i < w.len(); i++) txt.insert(txt.size(), w[i]);
        // near misses
        if ($urandom_range(3) == 0) begin
          if ($urandom_range(1)) txt.insert(txt.size(), ident_char());
          else void'(txt.pop_back());
        end
      end
      2: begin
        if ($urandom_range(7) == 0) begin
          txt.insert(txt.size(), ".");
        end else begin
          n = $urandom_range(1, 6);
          repeat (n) txt.insert(txt.size(), 8'("0" + $urandom_range(9)));
          if ($urandom_range(2) != 0) txt.insert($urandom_range(n), ".");
          if ($urandom_range(5) == 0) txt.insert($urandom_range(txt.size()), ".");
        end
      end
      3, 8: begin
        txt.insert(txt.size(),
                   ($urandom_range(4) == 0) ? 8'("_") : 8'("a" + $urandom_range(25)));
        repeat ($urandom_range(9)) txt.insert(txt.size(), ident_char());
      end
      4, 5: begin
        repeat ($urandom_range(1, 8))
          txt.insert(txt.size(), ($urandom_range(5) == 0) ? ident_char() : sym_char());
      end
      6: begin
        repeat ($urandom_range(1, 4)) txt.insert(txt.size(), 8'($urandom_range(255)));
      end
      7: begin
        repeat ($urandom_range(8, 14)) txt.insert(txt.size(), ident_char());
      end
      default: begin
        repeat ($urandom_range(1, 5)) txt.insert(txt.size(), sym_char());
        txt.insert($urandom_range(txt.size()), 8'($urandom_range(128, 255)));
      end
    endcase
    fin_mode = ($urandom_range(24) == 0) ? $urandom_range(2) : 3;
    for (int i = 0; i < txt.size(); i++)
      send_byte(txt[i], fin_mode == 0 && i == txt.size() - 1);
    case (fin_mode)
      0: ;
      1: send_byte(blanks[$urandom_range(5)], 1);
      2: begin
        send_byte(blanks[$urandom_range(5)], 0);
        send_byte(blanks[$urandom_range(5)], 1);
      end
      default: repeat ($urandom_range(1, 3)) send_byte(blanks[$urandom_range(5)], 0);
    endcase
  endtask

  initial begin
    int goal;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed text
    foreach (dir_tab[i])
      send_byte(dir_tab[i].c, dir_tab[i].last, dir_tab[i].fixed, dir_tab[i].cls);
    wait_drained();

    // Output held off while short identifiers keep arriving
    hold_trig = ~hold_trig;
    repeat (24) begin
      send_byte("a", 0);
      send_byte(CH_SPACE, 0);
    end
    wait_drained();

    // Random text in phases with differing input gap and output stall rates, draining between phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 46; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 46; end
        default: begin gap_pct = 13; stall_pct = 13; end
      endcase
      goal = text_items + RANDOM_ITEMS / 4;
      while (text_items < goal) send_token();
      wait_drained();
    end

    $display("covered %0d text bytes, %0d results (%0d final), %0d stalled input cycles",
             text_items, results_seen, finals_seen, stall_cycles);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("lexical_token_classifier_core test passed");
    else
      $display("lexical_token_classifier_core test failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ltc_pkg.sv
hw/rtl/ltc_front.sv
hw/rtl/ltc_queue.sv
hw/rtl/ltc_back.sv
hw/rtl/lexical_token_classifier_core.sv
sim/tb_top.sv
